[design/bsf_pkg.sv]
// Shared types, constants and helper functions for the base64 segment finder.
package bsf_pkg;

    // Buffer offsets saturate at this count
    localparam int MAX_CHARS = 65536;
    localparam int POS_W     = $clog2(MAX_CHARS + 1);
    localparam int CMP_W     = (POS_W > 17) ? POS_W : 17;

    // Output field widths and clamp limits
    localparam int START_W = 16;
    localparam int LEN_W   = 17;
    localparam logic [START_W-1:0] START_CLAMP = 16'hFFFF;
    localparam logic [LEN_W-1:0]   LEN_CLAMP   = 17'h10000;

    // Character codes
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;

    // Segment lengths come in groups of four characters
    localparam logic [POS_W-1:0] GROUP = POS_W'(4);

    typedef logic [POS_W-1:0] pos_t;

    // Outcome of closing a run
    typedef struct packed {
        logic found;
        logic wait_pad;
        pos_t start;
        pos_t length;
    } close_t;

    function automatic pos_t sat_inc(input pos_t v);
        pos_t r;
        if (v < POS_W'(MAX_CHARS))
            r = v + POS_W'(1);
        else
            r = POS_W'(MAX_CHARS);
        return r;
    endfunction

    function automatic logic is_b64(input logic [7:0] c);
        logic r;
        r = ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ)) ||
            ((c >= CH_D0) && (c <= CH_D9)) || (c == CH_PLUS) || (c == CH_SLASH);
        return r;
    endfunction

    // Decide what a finished run yields
    function automatic close_t close_run(input pos_t cnt, input pos_t begin_pos,
                                         input logic eq, input logic lst);
        close_t r;
        r.found    = 1'b0;
        r.wait_pad = 1'b0;
        r.start    = begin_pos;
        r.length   = cnt;
        unique case (cnt[1:0])
            2'd0:
            begin
                r.found = (cnt >= GROUP);
            end
            2'd1:
            begin
                if (cnt >= POS_W'(5))
                begin
                    r.start  = sat_inc(begin_pos);
                    r.length = cnt - POS_W'(1);
                    r.found  = 1'b1;
                end
            end
            2'd2:
            begin
                if (eq && !lst)
                    r.wait_pad = 1'b1;
                else
                begin
                    r.length = cnt - POS_W'(2);
                    r.found  = (r.length >= GROUP);
                end
            end
            default:
            begin
                if (eq)
                begin
                    r.length = cnt + POS_W'(1);
                    r.found  = 1'b1;
                end
                else
                begin
                    r.length = cnt - POS_W'(3);
                    r.found  = (r.length >= GROUP);
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [START_W-1:0] clamp_start(input pos_t v);
        logic [CMP_W-1:0] w;
        logic [START_W-1:0] r;
        w = CMP_W'(v);
        if (w > CMP_W'(START_CLAMP))
            r = START_CLAMP;
        else
            r = w[START_W-1:0];
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input pos_t v);
        logic [CMP_W-1:0] w;
        logic [LEN_W-1:0] r;
        w = CMP_W'(v);
        if (w > CMP_W'(LEN_CLAMP))
            r = LEN_CLAMP;
        else
            r = w[LEN_W-1:0];
        return r;
    endfunction

endpackage

[design/base64_segment_finder.sv]
// Top level of the base64 segment finder: input register, scan logic, result register.
//
// Characters of a buffer arrive one beat per clock, the final one flagged by last.
// The block reports once per buffer: a beat appears on the result side as soon as
// the first segment of base64 characters is settled (length a multiple of four,
// '=' padding included), or at the last character with found clear; the rest of
// that buffer is then swallowed. One character is taken every clock while the
// result side keeps up. A result is registered: the character that decides it
// waits in the input register, and the result register is loaded from it through
// the scan logic once the result side is free. A held result stalls the input
// only while the input register is also full. The character rate holds as the run
// tracking registers update on every consumed character.
// Offsets saturate at MAX_CHARS and raise too_long.
module base64_segment_finder
    import bsf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [7:0]         char_in,
    input  logic               last,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               found,
    output logic [START_W-1:0] seg_start,
    output logic [LEN_W-1:0]   seg_length,
    output logic               too_long
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // Scan state
    pos_t position_reg, position_next;
    pos_t run_begin_reg, run_begin_next;
    pos_t run_count_reg, run_count_next;
    logic pad_phase_reg, pad_phase_next;
    logic decided_reg, decided_next;
    logic overflowed_reg, overflowed_next;

    // Result register
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [START_W-1:0] out_start_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic               out_long_reg;

    logic out_free;
    logic advance;
    logic emit;
    logic seg_found;
    pos_t seg_s;
    pos_t seg_l;
    logic long_now;

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = in_valid_reg && out_free;
    assign item_stall = in_valid_reg && !out_free;

    // Capture a beat whenever the input register drains or is empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!item_stall)
            in_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            in_char_reg <= char_in;
            in_last_reg <= last;
        end
    end

    // Scan one character: track runs, padding and the decision
    always_comb
    begin
        logic   eq;
        logic   b64;
        logic   done;
        pos_t   rc_eff;
        pos_t   rb_eff;
        pos_t   cnt;
        close_t cr;

        position_next   = position_reg;
        run_begin_next  = run_begin_reg;
        run_count_next  = run_count_reg;
        pad_phase_next  = pad_phase_reg;
        decided_next    = decided_reg;
        overflowed_next = overflowed_reg;
        emit            = 1'b0;
        seg_found       = 1'b0;
        seg_s           = '0;
        seg_l           = '0;
        long_now        = overflowed_reg;

        eq     = (in_char_reg == CH_EQ);
        b64    = is_b64(in_char_reg);
        done   = 1'b0;
        rc_eff = run_count_reg;
        rb_eff = run_begin_reg;
        cnt    = '0;
        cr     = '0;

        if (!decided_reg)
        begin
            overflowed_next = overflowed_reg || (position_reg == POS_W'(MAX_CHARS));
            position_next   = sat_inc(position_reg);

            // Resolve a pending second '='
            if (pad_phase_reg)
            begin
                pad_phase_next = 1'b0;
                seg_s          = run_begin_reg;
                if (eq)
                begin
                    seg_l = run_count_reg + POS_W'(2);
                    done  = 1'b1;
                end
                else
                begin
                    seg_l = run_count_reg - POS_W'(2);
                    done  = (seg_l >= GROUP);
                end
                run_count_next = '0;
                rc_eff         = '0;
            end

            if (!done)
            begin
                if (b64)
                begin
                    // Extend the run, opening it here if empty
                    if (rc_eff == '0)
                    begin
                        run_begin_next = position_reg;
                        rb_eff         = position_reg;
                    end
                    cnt            = sat_inc(rc_eff);
                    run_count_next = cnt;
                    if (in_last_reg)
                    begin
                        cr             = close_run(cnt, rb_eff, 1'b0, 1'b1);
                        done           = cr.found;
                        seg_s          = cr.start;
                        seg_l          = cr.length;
                        run_count_next = '0;
                    end
                end
                else if (rc_eff != '0)
                begin
                    // Close the run on a non-base64 character
                    cr    = close_run(rc_eff, rb_eff, eq, in_last_reg);
                    done  = cr.found;
                    seg_s = cr.start;
                    seg_l = cr.length;
                    if (cr.wait_pad)
                        pad_phase_next = 1'b1;
                    else
                        run_count_next = '0;
                end
            end

            seg_found = done;
            emit      = done || in_last_reg;
            long_now  = overflowed_next;
            if (done)
                decided_next = 1'b1;
        end

        // Start over at the end of every buffer
        if (in_last_reg)
        begin
            position_next   = '0;
            run_begin_next  = '0;
            run_count_next  = '0;
            pad_phase_next  = 1'b0;
            decided_next    = 1'b0;
            overflowed_next = 1'b0;
        end
    end

    // Advance the scan state on every consumed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            run_begin_reg  <= '0;
            run_count_reg  <= '0;
            pad_phase_reg  <= 1'b0;
            decided_reg    <= 1'b0;
            overflowed_reg <= 1'b0;
        end
        else if (advance)
        begin
            position_reg   <= position_next;
            run_begin_reg  <= run_begin_next;
            run_count_reg  <= run_count_next;
            pad_phase_reg  <= pad_phase_next;
            decided_reg    <= decided_next;
            overflowed_reg <= overflowed_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= advance && emit;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_found_reg <= seg_found;
            out_start_reg <= seg_found ? clamp_start(seg_s) : '0;
            out_len_reg   <= seg_found ? clamp_len(seg_l) : '0;
            out_long_reg  <= long_now;
        end
    end

    assign result_valid = out_valid_reg;
    assign found        = out_found_reg;
    assign seg_start    = out_start_reg;
    assign seg_length   = out_len_reg;
    assign too_long     = out_long_reg;

endmodule

[design/bsf_checker.sv]
// Port-level checker for the base64 segment finder and its bind.
module bsf_checker
    import bsf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_stall,
    input logic               found,
    input logic [START_W-1:0] seg_start,
    input logic [LEN_W-1:0]   seg_length,
    input logic               too_long
);

    // A miss reports zero offset and length
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> (seg_start == '0 && seg_length == '0))
        else $error("miss result carries nonzero offset or length");

    // A hit is whole groups of four, at least one group
    a_hit_groups: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && found) |-> (seg_length[1:0] == 2'b00 && seg_length >= LEN_W'(4)))
        else $error("segment length not a positive multiple of four");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(found) &&
            $stable(seg_start) && $stable(seg_length) && $stable(too_long)))
        else $error("stalled result beat changed");

endmodule

bind base64_segment_finder bsf_checker u_bsf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .found        (found),
    .seg_start    (seg_start),
    .seg_length   (seg_length),
    .too_long     (too_long)
);
